/* rtl/skt_pkg.sv */
// ----------------------------------------------------------------------------
// skt_pkg
// Types and codes shared by the sorted key table cells and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

    localparam int unsigned KEY_W    = 64;
    localparam int unsigned HANDLE_W = 16;
    localparam int unsigned INDEX_W  = 5;
    localparam int unsigned COUNT_W  = 6;

    typedef logic [KEY_W-1:0]    t_key;
    typedef logic [HANDLE_W-1:0] t_handle;
    typedef logic [INDEX_W-1:0]  t_index;
    typedef logic [COUNT_W-1:0]  t_count;

    typedef enum logic [1:0] {
        CMD_ADD  = 2'd0,
        CMD_FIND = 2'd1,
        CMD_DEL  = 2'd2,
        CMD_LIST = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_ADDED   = 3'd0,
        ST_FOUND   = 3'd1,
        ST_DELETED = 3'd2,
        ST_MISSING = 3'd3,
        ST_FULL    = 3'd4,
        ST_LISTED  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACT,
        S_LIST
    } t_state;

    typedef struct packed {
        t_cmd    command;
        t_key    key;
        t_handle record_handle;
    } t_req;

    typedef struct packed {
        t_status status;
        t_key    entry_key;
        t_handle entry_handle;
        t_index  entry_index;
        t_count  entry_count;
        logic    last;
    } t_rsp;

    typedef struct packed {
        logic cmp;
        logic ins;
        logic del;
        logic rot;
    } t_cell_ctl;

endpackage

`default_nettype wire

/* rtl/skt_cell.sv */
// ----------------------------------------------------------------------------
// skt_cell
// One table slot: holds a key and handle, compares against a probe key and
// shifts entries with its neighbors on insert, delete and list rotation.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_cell #(
    parameter int unsigned KEY_BITS    = 64,
    parameter int unsigned HANDLE_BITS = 16,
    parameter int unsigned CNT_W       = 6,
    parameter int unsigned CELL_IDX    = 0
) (
    input  wire                     i_clk,
    input  skt_pkg::t_cell_ctl      i_ctl,
    input  wire [CNT_W-1:0]         i_count,
    input  wire [KEY_BITS-1:0]      i_cmp_key,
    input  wire [KEY_BITS-1:0]      i_new_key,
    input  wire [HANDLE_BITS-1:0]   i_new_hdl,
    input  wire [KEY_BITS-1:0]      i_left_key,
    input  wire [HANDLE_BITS-1:0]   i_left_hdl,
    input  wire                     i_left_at,
    input  wire                     i_left_eq,
    input  wire [KEY_BITS-1:0]      i_right_key,
    input  wire [HANDLE_BITS-1:0]   i_right_hdl,
    output logic [KEY_BITS-1:0]     o_key,
    output logic [HANDLE_BITS-1:0]  o_hdl,
    output logic                    o_at,
    output logic                    o_eq,
    output logic                    o_ins_first,
    output logic                    o_hit_first
);

    logic [KEY_BITS-1:0]    r_key;
    logic [HANDLE_BITS-1:0] r_hdl;
    logic                   r_gt;
    logic                   r_eq;
    logic                   w_vld;
    logic                   w_at;

    assign w_vld = i_count > CNT_W'(CELL_IDX);
    assign w_at  = r_gt || (i_count == CNT_W'(CELL_IDX));

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_gt <= w_vld && (r_key > i_cmp_key);
            r_eq <= w_vld && (r_key == i_cmp_key);
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_ctl.ins) begin
            if (w_at && i_left_at) begin
                r_key <= i_left_key;
                r_hdl <= i_left_hdl;
            end else if (w_at) begin
                r_key <= i_new_key;
                r_hdl <= i_new_hdl;
            end
        end else if (i_ctl.del) begin
            if (r_gt || r_eq) begin
                r_key <= i_right_key;
                r_hdl <= i_right_hdl;
            end
        end else if (i_ctl.rot) begin
            r_key <= i_right_key;
            r_hdl <= i_right_hdl;
        end
    end

    assign o_key       = r_key;
    assign o_hdl       = r_hdl;
    assign o_at        = w_at;
    assign o_eq        = r_eq;
    assign o_ins_first = w_at && !i_left_at;
    assign o_hit_first = r_eq && !i_left_eq;

endmodule

`default_nettype wire

/* rtl/sorted_key_table_unit.sv */
// ----------------------------------------------------------------------------
// sorted_key_table_unit
// Sorted table of key and record handle pairs built as a chain of cells.
// ----------------------------------------------------------------------------
// Add, find and delete are accepted when busy is low. In the cycle of the
// transfer every cell compares its key with the probe; in the cycle after it
// the cells shift and the result register loads. The result shows on o_rsp
// for one cycle under o_strobe, in the first cycle with busy low again, and
// must be taken then. List rotates the whole chain through cell 0 and stays
// busy until the rotation is complete, giving one result per stored entry
// (or one empty result) with last on the final one.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table_unit #(
    parameter int unsigned TABLE_DEPTH = 32,
    parameter int unsigned KEY_BITS    = 64,
    parameter int unsigned HANDLE_BITS = 16
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             start,
    output logic            busy,
    input  skt_pkg::t_req   i_req,
    output logic            o_strobe,
    output skt_pkg::t_rsp   o_rsp
);

    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

    skt_pkg::t_state        r_state;
    skt_pkg::t_state        n_state;
    skt_pkg::t_cmd          r_cmd;
    logic [KEY_BITS-1:0]    r_key;
    logic [HANDLE_BITS-1:0] r_hdl;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic [IDX_W-1:0]       r_lcnt;
    logic                   r_strobe;
    logic                   n_strobe;
    skt_pkg::t_rsp          r_rsp;
    skt_pkg::t_rsp          n_rsp;
    skt_pkg::t_cell_ctl     w_ctl;
    logic                   w_accept;
    logic [KEY_BITS-1:0]    w_in_key;

    logic [KEY_BITS-1:0]    w_key [TABLE_DEPTH];
    logic [HANDLE_BITS-1:0] w_hdl [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_at;
    logic [TABLE_DEPTH-1:0] w_eq;
    logic [TABLE_DEPTH-1:0] w_ins_first;
    logic [TABLE_DEPTH-1:0] w_hit_first;

    logic [IDX_W-1:0]       w_sel_idx;
    logic [HANDLE_BITS-1:0] w_sel_hdl;
    logic                   w_found;
    logic                   w_full;
    logic                   w_list_emit;
    logic                   w_list_empty;
    logic                   w_list_done;

    assign w_accept = start && !busy;
    assign w_in_key = i_req.key[KEY_BITS-1:0];

    for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
        localparam int unsigned LEFT  = (gi == 0) ? 0 : gi - 1;
        localparam int unsigned RIGHT = (gi + 1) % TABLE_DEPTH;

        skt_cell #(
            .KEY_BITS    (KEY_BITS),
            .HANDLE_BITS (HANDLE_BITS),
            .CNT_W       (CNT_W),
            .CELL_IDX    (gi)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_count     (r_count),
            .i_cmp_key   (w_in_key),
            .i_new_key   (r_key),
            .i_new_hdl   (r_hdl),
            .i_left_key  (w_key[LEFT]),
            .i_left_hdl  (w_hdl[LEFT]),
            .i_left_at   ((gi == 0) ? 1'b0 : w_at[LEFT]),
            .i_left_eq   ((gi == 0) ? 1'b0 : w_eq[LEFT]),
            .i_right_key (w_key[RIGHT]),
            .i_right_hdl (w_hdl[RIGHT]),
            .o_key       (w_key[gi]),
            .o_hdl       (w_hdl[gi]),
            .o_at        (w_at[gi]),
            .o_eq        (w_eq[gi]),
            .o_ins_first (w_ins_first[gi]),
            .o_hit_first (w_hit_first[gi])
        );
    end

    always_comb begin
        w_sel_idx = '0;
        w_sel_hdl = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if ((r_cmd == skt_pkg::CMD_ADD) ? w_ins_first[i] : w_hit_first[i]) begin
                w_sel_idx = w_sel_idx | IDX_W'(i);
                w_sel_hdl = w_sel_hdl | w_hdl[i];
            end
        end
    end

    assign w_found      = |w_hit_first;
    assign w_full       = r_count == CNT_W'(TABLE_DEPTH);
    assign w_list_emit  = CNT_W'(r_lcnt) < r_count;
    assign w_list_empty = (r_count == '0) && (r_lcnt == '0);
    assign w_list_done  = r_lcnt == IDX_W'(TABLE_DEPTH - 1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            skt_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_req.command == skt_pkg::CMD_LIST) ?
                              skt_pkg::S_LIST : skt_pkg::S_ACT;
                end
            end
            skt_pkg::S_ACT: begin
                n_state = skt_pkg::S_IDLE;
            end
            skt_pkg::S_LIST: begin
                if (w_list_done) begin
                    n_state = skt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = skt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        busy     = r_state != skt_pkg::S_IDLE;
        w_ctl    = '0;
        n_strobe = 1'b0;
        n_count  = r_count;
        n_rsp    = '0;
        unique case (r_state)
            skt_pkg::S_IDLE: begin
                w_ctl.cmp = w_accept;
            end
            skt_pkg::S_ACT: begin
                n_strobe   = 1'b1;
                n_rsp.last = 1'b1;
                unique case (r_cmd)
                    skt_pkg::CMD_ADD: begin
                        if (w_full) begin
                            n_rsp.status = skt_pkg::ST_FULL;
                        end else begin
                            w_ctl.ins          = 1'b1;
                            n_count            = r_count + CNT_W'(1);
                            n_rsp.status       = skt_pkg::ST_ADDED;
                            n_rsp.entry_key    = skt_pkg::t_key'(r_key);
                            n_rsp.entry_handle = skt_pkg::t_handle'(r_hdl);
                            n_rsp.entry_index  = skt_pkg::t_index'(w_sel_idx);
                        end
                    end
                    skt_pkg::CMD_FIND, skt_pkg::CMD_DEL: begin
                        if (!w_found) begin
                            n_rsp.status = skt_pkg::ST_MISSING;
                        end else begin
                            n_rsp.entry_key    = skt_pkg::t_key'(r_key);
                            n_rsp.entry_handle = skt_pkg::t_handle'(w_sel_hdl);
                            n_rsp.entry_index  = skt_pkg::t_index'(w_sel_idx);
                            if (r_cmd == skt_pkg::CMD_DEL) begin
                                w_ctl.del    = 1'b1;
                                n_count      = r_count - CNT_W'(1);
                                n_rsp.status = skt_pkg::ST_DELETED;
                            end else begin
                                n_rsp.status = skt_pkg::ST_FOUND;
                            end
                        end
                    end
                    default: begin
                        n_rsp.status = skt_pkg::ST_LISTED;
                    end
                endcase
                n_rsp.entry_count = skt_pkg::t_count'(n_count);
            end
            skt_pkg::S_LIST: begin
                w_ctl.rot          = 1'b1;
                n_strobe           = w_list_emit || w_list_empty;
                n_rsp.status       = skt_pkg::ST_LISTED;
                n_rsp.entry_count  = skt_pkg::t_count'(r_count);
                n_rsp.last         = w_list_empty ||
                                     (CNT_W'(r_lcnt) + CNT_W'(1) == r_count);
                if (w_list_emit) begin
                    n_rsp.entry_key    = skt_pkg::t_key'(w_key[0]);
                    n_rsp.entry_handle = skt_pkg::t_handle'(w_hdl[0]);
                    n_rsp.entry_index  = skt_pkg::t_index'(r_lcnt);
                end
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= skt_pkg::S_IDLE;
            r_count  <= '0;
            r_lcnt   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
            if (r_state == skt_pkg::S_LIST) begin
                r_lcnt <= r_lcnt + IDX_W'(1);
            end else begin
                r_lcnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_req.command;
            r_key <= w_in_key;
            r_hdl <= i_req.record_handle[HANDLE_BITS-1:0];
        end
        r_rsp <= n_rsp;
    end

    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule

`default_nettype wire

/* test/sorted_key_table_checker.sv */
// ----------------------------------------------------------------------------
// sorted_key_table_checker
// Watches the command and result channels of the sorted key table, keeps its
// own sorted table of keys and handles, and compares every result field by
// field with the replies its table predicts.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table_checker #(
    parameter int unsigned TABLE_DEPTH = 32
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_start,
    input  wire             i_busy,
    input  skt_pkg::t_req   i_req,
    input  wire             i_strobe,
    input  skt_pkg::t_rsp   i_rsp,
    output int              o_fail_count,
    output int              o_pending
);

    skt_pkg::t_key    table_key [TABLE_DEPTH];
    skt_pkg::t_handle table_handle [TABLE_DEPTH];
    int unsigned      table_used;
    skt_pkg::t_rsp    due_replies [$];
    int               fail_total;

    function automatic int field_differs(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    task automatic apply_command(input skt_pkg::t_req cmd);
        skt_pkg::t_rsp reply;
        int            pos;
        begin
            reply      = '0;
            reply.last = 1'b1;
            case (cmd.command)
                skt_pkg::CMD_ADD: begin
                    if (table_used >= TABLE_DEPTH) begin
                        reply.status      = skt_pkg::ST_FULL;
                        reply.entry_count = skt_pkg::t_count'(table_used);
                    end else begin
                        pos = int'(table_used);
                        while (pos > 0 && table_key[pos-1] > cmd.key) begin
                            table_key[pos]    = table_key[pos-1];
                            table_handle[pos] = table_handle[pos-1];
                            pos--;
                        end
                        table_key[pos]     = cmd.key;
                        table_handle[pos]  = cmd.record_handle;
                        table_used++;
                        reply.status       = skt_pkg::ST_ADDED;
                        reply.entry_key    = cmd.key;
                        reply.entry_handle = cmd.record_handle;
                        reply.entry_index  = skt_pkg::t_index'(pos);
                        reply.entry_count  = skt_pkg::t_count'(table_used);
                    end
                    due_replies.push_back(reply);
                end
                skt_pkg::CMD_FIND, skt_pkg::CMD_DEL: begin
                    pos = int'(table_used);
                    for (int i = 0; i < int'(table_used); i++) begin
                        if (table_key[i] == cmd.key) begin
                            pos = i;
                            break;
                        end
                    end
                    if (pos >= int'(table_used)) begin
                        reply.status      = skt_pkg::ST_MISSING;
                        reply.entry_count = skt_pkg::t_count'(table_used);
                    end else begin
                        reply.entry_key    = table_key[pos];
                        reply.entry_handle = table_handle[pos];
                        reply.entry_index  = skt_pkg::t_index'(pos);
                        if (cmd.command == skt_pkg::CMD_FIND) begin
                            reply.status = skt_pkg::ST_FOUND;
                        end else begin
                            for (int i = pos; i + 1 < int'(table_used); i++) begin
                                table_key[i]    = table_key[i+1];
                                table_handle[i] = table_handle[i+1];
                            end
                            table_used--;
                            reply.status = skt_pkg::ST_DELETED;
                        end
                        reply.entry_count = skt_pkg::t_count'(table_used);
                    end
                    due_replies.push_back(reply);
                end
                default: begin
                    reply.status = skt_pkg::ST_LISTED;
                    if (table_used == 0) begin
                        due_replies.push_back(reply);
                    end else begin
                        for (int i = 0; i < int'(table_used); i++) begin
                            reply.entry_key    = table_key[i];
                            reply.entry_handle = table_handle[i];
                            reply.entry_index  = skt_pkg::t_index'(i);
                            reply.entry_count  = skt_pkg::t_count'(table_used);
                            reply.last         = (i + 1 == int'(table_used));
                            due_replies.push_back(reply);
                        end
                    end
                end
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        skt_pkg::t_rsp want;
        if (!i_rst_n) begin
            table_used = 0;
            due_replies.delete();
            fail_total = 0;
        end else begin
            // compare before queuing new replies: a new transfer never answers on its own edge
            if (i_strobe) begin
                if (due_replies.size() == 0) begin
                    $error("unexpected result: status %0d key %0h", i_rsp.status,
                           i_rsp.entry_key);
                    fail_total++;
                end else begin
                    want = due_replies.pop_front();
                    fail_total += field_differs("status", 64'(want.status), 64'(i_rsp.status));
                    fail_total += field_differs("entry_key", 64'(want.entry_key),
                                                64'(i_rsp.entry_key));
                    fail_total += field_differs("entry_handle", 64'(want.entry_handle),
                                                64'(i_rsp.entry_handle));
                    fail_total += field_differs("entry_index", 64'(want.entry_index),
                                                64'(i_rsp.entry_index));
                    fail_total += field_differs("entry_count", 64'(want.entry_count),
                                                64'(i_rsp.entry_count));
                    fail_total += field_differs("last", 64'(want.last), 64'(i_rsp.last));
                end
            end
            if (i_start && !i_busy) begin
                apply_command(i_req);
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= due_replies.size();
    end

endmodule

`default_nettype wire

/* test/sorted_key_table_unit_tb.sv */
// ----------------------------------------------------------------------------
// sorted_key_table_unit_tb
// Drives add, find, delete and list commands into the sorted key table: a
// directed opening on the extremes and duplicate keys, then alternating fill
// and drain phases drawn from a small key pool with random gaps, and reports
// the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table_unit_tb;

    localparam int POOL_SIZE    = 10;
    localparam int PHASE_ITEMS  = 75;
    localparam int PHASES       = 4;
    localparam int CYCLE_LIMIT  = 200000;

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start   = 1'b0;
    logic           busy;
    skt_pkg::t_req  req     = '0;
    logic           strobe;
    skt_pkg::t_rsp  rsp;
    int             fail_count;
    int             pending;
    int             cycle_count = 0;
    skt_pkg::t_key  key_pool [POOL_SIZE];

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    sorted_key_table_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (req),
        .o_strobe (strobe),
        .o_rsp    (rsp)
    );

    sorted_key_table_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (req),
        .i_strobe     (strobe),
        .i_rsp        (rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic skt_pkg::t_key any_key();
        return {$urandom, $urandom};
    endfunction

    function automatic skt_pkg::t_key pick_key();
        if ($urandom_range(0, 9) == 0) begin
            return any_key();
        end
        return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // hold start until the transfer, then, if gaps are on, maybe drop it for a random gap
    task automatic issue(input skt_pkg::t_cmd cmd, input skt_pkg::t_key key,
                         input skt_pkg::t_handle handle, input bit gaps_on);
        skt_pkg::t_req item;
        begin
            item.command       = cmd;
            item.key           = key;
            item.record_handle = handle;
            start <= 1'b1;
            req   <= item;
            do @(posedge i_clk); while (busy);
            if (gaps_on && $urandom_range(0, 3) == 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        int            roll;
        int            idx;
        bit            gaps_on;
        skt_pkg::t_cmd cmd;

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) begin
            key_pool[i] = any_key();
        end
        key_pool[3] = key_pool[2] ^ skt_pkg::t_key'(1);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        issue(skt_pkg::CMD_LIST, key_pool[2], 16'h0000, 1'b1);
        issue(skt_pkg::CMD_FIND, key_pool[2], 16'h0000, 1'b1);
        issue(skt_pkg::CMD_DEL,  key_pool[2], 16'hFFFF, 1'b1);
        issue(skt_pkg::CMD_ADD,  '1,          16'hFFFF, 1'b1);
        issue(skt_pkg::CMD_ADD,  '0,          16'h0000, 1'b0);
        issue(skt_pkg::CMD_ADD,  key_pool[2], 16'h1111, 1'b0);
        issue(skt_pkg::CMD_ADD,  key_pool[2], 16'h2222, 1'b1);
        issue(skt_pkg::CMD_ADD,  key_pool[2], 16'h3333, 1'b0);
        issue(skt_pkg::CMD_ADD,  key_pool[3], 16'h4444, 1'b1);
        issue(skt_pkg::CMD_FIND, key_pool[2], 16'hABCD, 1'b0);
        issue(skt_pkg::CMD_FIND, '1,          16'h0000, 1'b1);
        issue(skt_pkg::CMD_LIST, '0,          16'h0000, 1'b0);
        issue(skt_pkg::CMD_DEL,  key_pool[2], 16'h0000, 1'b1);
        issue(skt_pkg::CMD_FIND, key_pool[2], 16'h0000, 1'b0);
        issue(skt_pkg::CMD_DEL,  '1,          16'h0000, 1'b1);
        issue(skt_pkg::CMD_DEL,  '0,          16'h0000, 1'b0);
        issue(skt_pkg::CMD_FIND, '0,          16'h0000, 1'b1);
        issue(skt_pkg::CMD_ADD,  any_key(),   16'h5A5A, 1'b1);
        issue(skt_pkg::CMD_LIST, any_key(),   16'hA5A5, 1'b0);

        // even phases fill the table past full, odd phases drain it
        for (int ph = 0; ph < PHASES; ph++) begin
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                idx  = ph * PHASE_ITEMS + n;
                roll = $urandom_range(0, 99);
                if (ph % 2 == 0) begin
                    cmd = (roll < 80) ? skt_pkg::CMD_ADD :
                          (roll < 88) ? skt_pkg::CMD_FIND :
                          (roll < 95) ? skt_pkg::CMD_DEL : skt_pkg::CMD_LIST;
                end else begin
                    cmd = (roll < 12) ? skt_pkg::CMD_ADD :
                          (roll < 27) ? skt_pkg::CMD_FIND :
                          (roll < 92) ? skt_pkg::CMD_DEL : skt_pkg::CMD_LIST;
                end
                gaps_on = (idx < PHASES * PHASE_ITEMS - 40) && ((idx / 20) % 3 != 2);
                issue(cmd, pick_key(), skt_pkg::t_handle'($urandom_range(0, 65535)),
                      gaps_on);
            end
        end
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
